// File: hw/rtl/wpc_pkg.sv
package wpc_pkg;

  // Default coordinate width (signed fixed point, Q11.4 at 16 bits)
  localparam int unsigned CoordWidthDef = 16;

  // Configuration register indexes
  localparam logic [1:0] RegVertexA = 2'd0;
  localparam logic [1:0] RegVertexB = 2'd1;
  localparam logic [1:0] RegVertexC = 2'd2;

  // Push control carried alongside the divider
  typedef struct packed {
    logic       hit;    // all wall tests passed
    logic       qzero;  // degenerate wall, squared normal length is zero
    logic [2:0] neg;    // push sign per axis
  } push_ctl_t;

endpackage

// File: hw/rtl/wall_point_collision_pushback.sv
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// The restoring divider takes COORD_WIDTH + 2 steps, one per stage.
// Reset clears the three wall vertices to zero and empties the pipeline.
module wall_point_collision_pushback #(
  parameter int unsigned COORD_WIDTH = wpc_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [3*COORD_WIDTH-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] new_x_i,
  input  logic signed [COORD_WIDTH-1:0] new_y_i,
  input  logic signed [COORD_WIDTH-1:0] new_z_i,
  input  logic signed [COORD_WIDTH-1:0] old_x_i,
  input  logic signed [COORD_WIDTH-1:0] old_y_i,
  input  logic signed [COORD_WIDTH-1:0] old_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic                          hit_o
);

  import wpc_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned NMW  = 2 * DW;
  localparam int unsigned NW   = NMW + 1;
  localparam int unsigned QW   = 2 * NMW + 2;
  localparam int unsigned NUMW = 3 * W + 4 + NMW;
  localparam int unsigned QB   = W + 2;
  localparam int unsigned SW   = QB + 2;
  localparam logic signed [SW-1:0] SatHi = SW'((1 << (W - 1)) - 1);
  localparam logic signed [SW-1:0] SatLo = -SatHi - SW'(1);

  logic [3*W-1:0]      vert_a_q, vert_b_q, vert_c_q;
  logic                adv;
  logic signed [W-1:0] pin [3];
  logic signed [W-1:0] oin [3];

  logic                t_vld, t_hit;
  logic signed [W-1:0] t_p [3];
  logic signed [DW-1:0] t_mv [3];
  logic signed [NW-1:0] t_n [3];

  logic                j_vld;
  push_ctl_t           j_ctl;
  logic signed [W-1:0] j_p [3];
  logic [NUMW-1:0]     j_num [3];
  logic [QW-1:0]       j_den;

  logic                dvld;
  push_ctl_t           dctl;
  logic signed [W-1:0] dp [3];
  logic [QB-1:0]       quo_w [3];

  logic signed [SW-1:0] mag_w [3], sum_w [3];
  logic signed [W-1:0]  res_d [3], res_q [3];
  logic                 out_vld_q, hit_q;

  // Hold the pipeline only while a finished word waits
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Write wall vertices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_a_q <= '0;
      vert_b_q <= '0;
      vert_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegVertexA: vert_a_q <= cfg_data_i;
        RegVertexB: vert_b_q <= cfg_data_i;
        RegVertexC: vert_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pin[0] = new_x_i;
  assign pin[1] = new_y_i;
  assign pin[2] = new_z_i;
  assign oin[0] = old_x_i;
  assign oin[1] = old_y_i;
  assign oin[2] = old_z_i;

  wpc_test #(.W(W)) u_test (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_valid_i),
    .va_i   (vert_a_q),
    .vb_i   (vert_b_q),
    .vc_i   (vert_c_q),
    .p_i    (pin),
    .o_i    (oin),
    .vld_o  (t_vld),
    .hit_o  (t_hit),
    .p_o    (t_p),
    .mv_o   (t_mv),
    .n_o    (t_n)
  );

  wpc_proj #(.W(W)) u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (t_vld),
    .hit_i  (t_hit),
    .p_i    (t_p),
    .mv_i   (t_mv),
    .n_i    (t_n),
    .vld_o  (j_vld),
    .ctl_o  (j_ctl),
    .p_o    (j_p),
    .num_o  (j_num),
    .den_o  (j_den)
  );

  wpc_div #(.W(W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (j_vld),
    .ctl_i  (j_ctl),
    .p_i    (j_p),
    .num_i  (j_num),
    .den_i  (j_den),
    .vld_o  (dvld),
    .ctl_o  (dctl),
    .p_o    (dp),
    .quo_o  (quo_w)
  );

  // Apply signed push on a hit with a nonzero normal, and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_w[k] = $signed(SW'(quo_w[k]));
      if (dctl.hit && !dctl.qzero) begin
        sum_w[k] = SW'(dp[k]) + (dctl.neg[k] ? -mag_w[k] : mag_w[k]);
      end else begin
        sum_w[k] = SW'(dp[k]);
      end
      if (sum_w[k] > SatHi) begin
        res_d[k] = W'(SatHi);
      end else if (sum_w[k] < SatLo) begin
        res_d[k] = W'(SatLo);
      end else begin
        res_d[k] = W'(sum_w[k]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dvld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      hit_q <= dctl.hit;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign hit_o       = hit_q;

  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvld && dctl.hit && !dctl.qzero |->
      (quo_w[0][QB-1] | quo_w[1][QB-1] | quo_w[2][QB-1]) == 1'b0)
    else $error("push exceeds motion bound");

endmodule

// File: hw/rtl/wpc_test.sv
module wpc_test #(
  parameter int unsigned W = wpc_pkg::CoordWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  logic [3*W-1:0]       va_i,
  input  logic [3*W-1:0]       vb_i,
  input  logic [3*W-1:0]       vc_i,
  input  logic signed [W-1:0]  p_i [3],
  input  logic signed [W-1:0]  o_i [3],
  output logic                 vld_o,
  output logic                 hit_o,
  output logic signed [W-1:0]  p_o [3],
  output logic signed [W:0]    mv_o [3],
  output logic signed [2*W+2:0] n_o [3]
);

  localparam int unsigned DW   = W + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned NW   = PW + 1;

  logic signed [W-1:0]  a_s [3];
  logic signed [W-1:0]  b_s [3];
  logic signed [W-1:0]  c_s [3];

  // Stage 1: edge and offset vectors
  logic signed [DW-1:0] e0_d [3], e1_d [3], pa_d [3], pb_d [3], mv_d [3];
  logic                 yok_d;
  logic signed [DW-1:0] e0_q [3], e1_q [3], pa_q [3], pb_q [3], mv1_q [3];
  logic signed [W-1:0]  p1_q [3];
  logic                 yok1_q, v1_q;

  // Stage 2: products
  logic signed [PW-1:0] mda_d [3], mdb_d [3], mn_d [6];
  logic signed [PW-1:0] cy0_d, cy1_d;
  logic signed [PW-1:0] mda_q [3], mdb_q [3], mn_q [6];
  logic signed [PW-1:0] cy0_q, cy1_q;
  logic signed [DW-1:0] mv2_q [3];
  logic signed [W-1:0]  p2_q [3];
  logic                 yok2_q, v2_q;

  // Stage 3: sums and the wall test
  logic signed [SUMW-1:0] da_d, sb_d;
  logic signed [NW-1:0]   cy_d;
  logic signed [NW-1:0]   n_d [3];
  logic                   hit_d;
  logic signed [NW-1:0]   n3_q [3];
  logic signed [DW-1:0]   mv3_q [3];
  logic signed [W-1:0]    p3_q [3];
  logic                   hit3_q, v3_q;

  // Unpack vertices
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_s[k] = va_i[k*W +: W];
      b_s[k] = vb_i[k*W +: W];
      c_s[k] = vc_i[k*W +: W];
    end
  end

  // Form differences and the height window test
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0_d[k] = DW'(b_s[k]) - DW'(a_s[k]);
      e1_d[k] = DW'(c_s[k]) - DW'(a_s[k]);
      pa_d[k] = DW'(p_i[k]) - DW'(a_s[k]);
      pb_d[k] = DW'(p_i[k]) - DW'(b_s[k]);
      mv_d[k] = DW'(o_i[k]) - DW'(p_i[k]);
    end
    yok_d = (p_i[1] <= a_s[1]) && (p_i[1] >= c_s[1]);
  end

  // Multiply edge terms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mda_d[k] = e0_q[k] * pa_q[k];
      mdb_d[k] = e0_q[k] * pb_q[k];
    end
    cy0_d    = e0_q[2] * pa_q[0];
    cy1_d    = e0_q[0] * pa_q[2];
    mn_d[0]  = e0_q[1] * e1_q[2];
    mn_d[1]  = e0_q[2] * e1_q[1];
    mn_d[2]  = e0_q[2] * e1_q[0];
    mn_d[3]  = e0_q[0] * e1_q[2];
    mn_d[4]  = e0_q[0] * e1_q[1];
    mn_d[5]  = e0_q[1] * e1_q[0];
  end

  // Sum the dot products, the cross term and the normal; the far end dot
  // is the negated sum against B, so it passes when that sum is not positive
  always_comb begin
    da_d   = SUMW'(mda_q[0]) + SUMW'(mda_q[1]) + SUMW'(mda_q[2]);
    sb_d   = SUMW'(mdb_q[0]) + SUMW'(mdb_q[1]) + SUMW'(mdb_q[2]);
    cy_d   = NW'(cy0_q) - NW'(cy1_q);
    n_d[0] = NW'(mn_q[0]) - NW'(mn_q[1]);
    n_d[1] = NW'(mn_q[2]) - NW'(mn_q[3]);
    n_d[2] = NW'(mn_q[4]) - NW'(mn_q[5]);
    hit_d  = yok2_q && !da_d[SUMW-1] && (sb_d[SUMW-1] || (sb_d == '0)) && cy_d[NW-1];
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e0_q   <= e0_d;
      e1_q   <= e1_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      mv1_q  <= mv_d;
      p1_q   <= p_i;
      yok1_q <= yok_d;
      mda_q  <= mda_d;
      mdb_q  <= mdb_d;
      mn_q   <= mn_d;
      cy0_q  <= cy0_d;
      cy1_q  <= cy1_d;
      mv2_q  <= mv1_q;
      p2_q   <= p1_q;
      yok2_q <= yok1_q;
      n3_q   <= n_d;
      mv3_q  <= mv2_q;
      p3_q   <= p2_q;
      hit3_q <= hit_d;
    end
  end

  assign vld_o = v3_q;
  assign hit_o = hit3_q;
  assign p_o   = p3_q;
  assign mv_o  = mv3_q;
  assign n_o   = n3_q;

endmodule

// File: hw/rtl/wpc_proj.sv
module wpc_proj #(
  parameter int unsigned W = wpc_pkg::CoordWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      vld_i,
  input  logic                      hit_i,
  input  logic signed [W-1:0]       p_i [3],
  input  logic signed [W:0]         mv_i [3],
  input  logic signed [2*W+2:0]     n_i [3],
  output logic                      vld_o,
  output wpc_pkg::push_ctl_t        ctl_o,
  output logic signed [W-1:0]       p_o [3],
  output logic [5*W+5:0]            num_o [3],
  output logic [4*W+5:0]            den_o
);

  import wpc_pkg::*;

  localparam int unsigned DW   = W + 1;
  localparam int unsigned NMW  = 2 * DW;
  localparam int unsigned NW   = NMW + 1;
  localparam int unsigned QW   = 2 * NMW + 2;
  localparam int unsigned DMW  = W + NMW + 2;
  localparam int unsigned DDW  = DMW + 2;
  localparam int unsigned NUMW = DMW + NMW;
  localparam int unsigned HL   = (DMW + 1) / 2;
  localparam int unsigned HH   = DMW - HL;

  // Stage 4: motion along the normal and squared components
  logic signed [DMW-1:0]  dm_d [3];
  logic signed [2*NW-1:0] sq_d [3];
  logic [NMW-1:0]         nmag_d [3];
  logic signed [DMW-1:0]  dm_q [3];
  logic [2*NMW-1:0]       nsq_q [3];
  logic [NMW-1:0]         nmag4_q [3];
  logic [2:0]             nneg4_q;
  logic signed [W-1:0]    p4_q [3];
  logic                   hit4_q, v4_q;

  // Stage 5: dot and length sums
  logic signed [DDW-1:0]  d_d;
  logic [QW-1:0]          q_d;
  logic signed [DDW-1:0]  d_q;
  logic [QW-1:0]          q5_q;
  logic [NMW-1:0]         nmag5_q [3];
  logic [2:0]             nneg5_q;
  logic signed [W-1:0]    p5_q [3];
  logic                   hit5_q, v5_q;

  // Stage 6: magnitude and signs
  logic                   dneg_w;
  logic [DMW-1:0]         dmag_d;
  push_ctl_t              ctl6_d;
  logic [DMW-1:0]         dmag_q;
  logic [QW-1:0]          q6_q;
  logic [NMW-1:0]         nmag6_q [3];
  push_ctl_t              ctl6_q;
  logic signed [W-1:0]    p6_q [3];
  logic                   v6_q;

  // Stage 7: partial products of the numerator
  logic [HL+NMW-1:0]      pl_d [3], pl_q [3];
  logic [HH+NMW-1:0]      ph_d [3], ph_q [3];
  logic [QW-1:0]          q7_q;
  push_ctl_t              ctl7_q;
  logic signed [W-1:0]    p7_q [3];
  logic                   v7_q;

  // Stage 8: numerator
  logic [NUMW-1:0]        num_d [3], num_q [3];
  logic [QW-1:0]          q8_q;
  push_ctl_t              ctl8_q;
  logic signed [W-1:0]    p8_q [3];
  logic                   v8_q;

  // Multiply motion by normal, square the normal
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dm_d[k]   = mv_i[k] * n_i[k];
      sq_d[k]   = n_i[k] * n_i[k];
      nmag_d[k] = NMW'(n_i[k][NW-1] ? -n_i[k] : n_i[k]);
    end
  end

  // Sum the three axes
  always_comb begin
    d_d = DDW'(dm_q[0]) + DDW'(dm_q[1]) + DDW'(dm_q[2]);
    q_d = QW'(nsq_q[0]) + QW'(nsq_q[1]) + QW'(nsq_q[2]);
  end

  // Split dot into sign and magnitude, set push signs
  always_comb begin
    dneg_w       = d_q[DDW-1];
    dmag_d       = DMW'(dneg_w ? -d_q : d_q);
    ctl6_d.hit   = hit5_q;
    ctl6_d.qzero = (q5_q == '0);
    ctl6_d.neg   = {3{dneg_w}} ^ nneg5_q;
  end

  // Multiply magnitude halves by each normal component, then combine
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pl_d[k]  = dmag_q[HL-1:0] * nmag6_q[k];
      ph_d[k]  = dmag_q[DMW-1:HL] * nmag6_q[k];
      num_d[k] = (NUMW'(ph_q[k]) << HL) + NUMW'(pl_q[k]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= vld_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        dm_q[k]    <= dm_d[k];
        nsq_q[k]   <= sq_d[k][2*NMW-1:0];
        nneg4_q[k] <= n_i[k][NW-1];
      end
      nmag4_q <= nmag_d;
      p4_q    <= p_i;
      hit4_q  <= hit_i;
      d_q     <= d_d;
      q5_q    <= q_d;
      nmag5_q <= nmag4_q;
      nneg5_q <= nneg4_q;
      p5_q    <= p4_q;
      hit5_q  <= hit4_q;
      dmag_q  <= dmag_d;
      q6_q    <= q5_q;
      nmag6_q <= nmag5_q;
      ctl6_q  <= ctl6_d;
      p6_q    <= p5_q;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      q7_q    <= q6_q;
      ctl7_q  <= ctl6_q;
      p7_q    <= p6_q;
      num_q   <= num_d;
      q8_q    <= q7_q;
      ctl8_q  <= ctl7_q;
      p8_q    <= p7_q;
    end
  end

  assign vld_o = v8_q;
  assign ctl_o = ctl8_q;
  assign p_o   = p8_q;
  assign num_o = num_q;
  assign den_o = q8_q;

endmodule

// File: hw/rtl/wpc_div.sv
module wpc_div #(
  parameter int unsigned W = wpc_pkg::CoordWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  wpc_pkg::push_ctl_t   ctl_i,
  input  logic signed [W-1:0]  p_i [3],
  input  logic [5*W+5:0]       num_i [3],
  input  logic [4*W+5:0]       den_i,
  output logic                 vld_o,
  output wpc_pkg::push_ctl_t   ctl_o,
  output logic signed [W-1:0]  p_o [3],
  output logic [W+1:0]         quo_o [3]
);

  import wpc_pkg::*;

  localparam int unsigned DW   = W + 1;
  localparam int unsigned NMW  = 2 * DW;
  localparam int unsigned QW   = 2 * NMW + 2;
  localparam int unsigned NUMW = 3 * W + 4 + NMW;
  localparam int unsigned QB   = W + 2;

  // One restoring step per stage; the quotient fits in QB bits, so the
  // top numerator bits start below the divisor
  logic [QW-1:0]       den_q [QB];
  logic [QW-1:0]       rem_q [3][QB];
  logic [QB-1:0]       bits_q [3][QB];
  logic [QB-1:0]       vld_q;
  push_ctl_t           ctl_q [QB];
  logic signed [W-1:0] p_q [QB][3];

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [QW-1:0] den_s;

    if (s == 0) begin : g_dsrc
      assign den_s = den_i;
    end else begin : g_dsrc
      assign den_s = den_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        den_q[s] <= den_s;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [QW-1:0] rem_s;
      logic [QB-1:0] bits_s;
      logic [QW:0]   trial;
      logic [QW:0]   diff;
      logic          take;

      if (s == 0) begin : g_src
        assign rem_s  = QW'(num_i[l][NUMW-1:QB]);
        assign bits_s = num_i[l][QB-1:0];
      end else begin : g_src
        assign rem_s  = rem_q[l][s-1];
        assign bits_s = bits_q[l][s-1];
      end

      // Shift in the next numerator bit, subtract when it fits
      assign trial = {rem_s, bits_s[QB-1]};
      assign diff  = trial - {1'b0, den_s};
      assign take  = !diff[QW];

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[l][s]  <= take ? diff[QW-1:0] : trial[QW-1:0];
          bits_q[l][s] <= {bits_s[QB-2:0], take};
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[QB-2:0], vld_i};
    end
  end

  // Carry sideband alongside the steps
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q[0] <= ctl_i;
      p_q[0]   <= p_i;
      for (int s = 1; s < QB; s++) begin
        ctl_q[s] <= ctl_q[s-1];
        p_q[s]   <= p_q[s-1];
      end
    end
  end

  assign vld_o = vld_q[QB-1];
  assign ctl_o = ctl_q[QB-1];
  assign p_o   = p_q[QB-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo_o[l] = bits_q[l][QB-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_chk
    a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[QB-1] && (den_q[QB-1] != '0) |-> rem_q[l][QB-1] < den_q[QB-1])
      else $error("divider remainder not below divisor");
  end

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(vld_q))
    else $error("divider valid bits moved during stall");

endmodule
